FILE: rtl/acht_pkg.sv
// Shared types and constants for the chained hash table accumulator.
// No dependencies.
`timescale 1ns / 1ps

package acht_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = 8;    // entry / bucket index width
    localparam int CNT_W   = 9;    // entry count, holds ENTRIES

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic latch_in;    // take the input transfer, clear result fields
        logic do_clear;    // empty all buckets
        logic node_head;   // walk pointer <= bucket head
        logic node_next;   // walk pointer <= link of current entry
        logic set_ok;
        logic set_found;   // result value <= current entry value
        logic do_alloc;    // write new entry at head of chain
        logic do_update;   // saturating add into current entry
        logic load_out;    // move result into output register
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       full;
        logic       head_empty;
        logic       key_hit;
        logic       next_empty;
        logic       out_free;
    } t_ctl_sts;

endpackage

FILE: rtl/acht_ctrl.sv
// Command sequencer for the hash table: dispatch, chain walk, write-back.
// Depends on acht_pkg.
`timescale 1ns / 1ps

module acht_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  acht_pkg::t_ctl_sts  i_sts,
    output acht_pkg::t_ctl_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_NODE  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_ALLOC = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state, n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_HEAD;
                end
            end
            S_HEAD: begin
                // head read issued this cycle, data seen in S_NODE; dispatch on command
                case (i_sts.cmd)
                    acht_pkg::CMD_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                        o_cmd.set_ok   = 1'b1;
                        n_state        = S_DONE;
                    end
                    acht_pkg::CMD_LOOKUP: begin
                        n_state = S_NODE;
                    end
                    acht_pkg::CMD_INSERT: begin
                        n_state = i_sts.full ? S_DONE : S_NODE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_NODE: begin
                o_cmd.node_head = 1'b1;
                if (!i_sts.head_empty) begin
                    n_state = S_READ;
                end else if (i_sts.cmd == acht_pkg::CMD_LOOKUP) begin
                    o_cmd.set_ok = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.key_hit) begin
                    if (i_sts.cmd == acht_pkg::CMD_LOOKUP) begin
                        o_cmd.set_ok    = 1'b1;
                        o_cmd.set_found = 1'b1;
                        n_state         = S_DONE;
                    end else begin
                        n_state = S_UPD;
                    end
                end else if (!i_sts.next_empty) begin
                    o_cmd.node_next = 1'b1;
                    n_state         = S_READ;
                end else if (i_sts.cmd == acht_pkg::CMD_LOOKUP) begin
                    o_cmd.set_ok = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin
                o_cmd.do_alloc = 1'b1;
                o_cmd.set_ok   = 1'b1;
                n_state        = S_DONE;
            end
            S_UPD: begin
                o_cmd.do_update = 1'b1;
                o_cmd.set_ok    = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/acht_dp.sv
// Datapath: bucket heads with valid bits, entry memories, counters,
// saturating adder and output register. Depends on acht_pkg.
`timescale 1ns / 1ps

module acht_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [8:0]          i_cfg_wr_data,
    input  logic [1:0]          i_cmd,
    input  logic signed [31:0]  i_key,
    input  logic signed [31:0]  i_value,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic                o_ok,
    output logic signed [31:0]  o_found_value,
    output logic [8:0]          o_entry_count,
    input  acht_pkg::t_ctl_cmd  i_cmd_bus,
    output acht_pkg::t_ctl_sts  o_sts
);

    localparam int IW = acht_pkg::IDX_W;
    localparam int CW = acht_pkg::CNT_W;

    logic [8:0]  r_cap;
    logic [CW-1:0] r_used;
    logic [1:0]  r_cmd;
    logic [31:0] r_key, r_val;
    logic [IW-1:0] r_bucket;
    logic [IW:0] r_node;        // MSB set = end of chain
    logic        r_ok;
    logic [31:0] r_found;

    // memories
    logic [IW-1:0] head_mem [acht_pkg::ENTRIES];
    logic [IW:0]   link_mem [acht_pkg::ENTRIES];
    logic [31:0]   key_mem  [acht_pkg::ENTRIES];
    logic [31:0]   val_mem  [acht_pkg::ENTRIES];
    logic [acht_pkg::ENTRIES-1:0] r_hv;

    logic [IW-1:0] r_head_q;
    logic          r_hv_q;
    logic [IW:0]   r_nl_q;
    logic [31:0]   r_ek_q, r_ev_q;

    // effective capacity and bucket mask
    logic [CW-1:0] eff_cap;
    logic [IW-1:0] m0, mask;
    always_comb begin
        eff_cap = r_cap;
        if (r_cap == '0) eff_cap = CW'(1);
        if (r_cap > CW'(acht_pkg::ENTRIES)) eff_cap = CW'(acht_pkg::ENTRIES);
        m0   = IW'(eff_cap - CW'(1));
        mask = m0 | (m0 >> 1);
        mask = mask | (mask >> 2);
        mask = mask | (mask >> 4);
    end

    // saturating add
    logic [32:0] sum;
    logic [31:0] sat;
    always_comb begin
        sum = {r_ev_q[31], r_ev_q} + {r_val[31], r_val};
        if (sum[32] != sum[31]) sat = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else                    sat = sum[31:0];
    end

    logic r_out_valid;
    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.full       = (r_used >= eff_cap);
        o_sts.head_empty = !r_hv_q;
        o_sts.key_hit    = (r_ek_q == r_key);
        o_sts.next_empty = r_nl_q[IW];
        o_sts.out_free   = out_free;
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        r_head_q <= head_mem[r_bucket];
        r_hv_q   <= r_hv[r_bucket];
        r_nl_q   <= link_mem[r_node[IW-1:0]];
        r_ek_q   <= key_mem[r_node[IW-1:0]];
        r_ev_q   <= val_mem[r_node[IW-1:0]];
        if (i_cmd_bus.do_alloc) begin
            head_mem[r_bucket]        <= r_used[IW-1:0];
            link_mem[r_used[IW-1:0]]  <= {!r_hv_q, r_head_q};
            key_mem[r_used[IW-1:0]]   <= r_key;
            val_mem[r_used[IW-1:0]]   <= r_val;
        end
        if (i_cmd_bus.do_update) begin
            val_mem[r_node[IW-1:0]] <= sat;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.latch_in) begin
            r_cmd    <= i_cmd;
            r_key    <= i_key;
            r_val    <= i_value;
            r_bucket <= i_key[IW-1:0] & mask;
            r_ok     <= 1'b0;
            r_found  <= '0;
        end
        if (i_cmd_bus.set_ok)    r_ok    <= 1'b1;
        if (i_cmd_bus.set_found) r_found <= r_ev_q;
        if (i_cmd_bus.node_head) r_node  <= {!r_hv_q, r_head_q};
        if (i_cmd_bus.node_next) r_node  <= r_nl_q;
        if (i_cmd_bus.load_out) begin
            o_ok          <= r_ok;
            o_found_value <= r_found;
            o_entry_count <= r_used;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= 9'd256;
            r_used      <= '0;
            r_hv        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_cap <= i_cfg_wr_data;
            if (i_cmd_bus.do_clear) begin
                r_hv   <= '0;
                r_used <= '0;
            end
            if (i_cmd_bus.do_alloc) begin
                r_hv[r_bucket] <= 1'b1;
                r_used         <= r_used + CW'(1);
            end
            if (i_cmd_bus.load_out)      r_out_valid <= 1'b1;
            else if (!i_out_stall)       r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(acht_pkg::ENTRIES))
        else $error("entry count above table size");
    a_alloc_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_bus.do_alloc |=> r_used == $past(r_used) + CW'(1))
        else $error("allocation did not bump entry count");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_bus.do_clear |=> (r_used == '0) && (r_hv == '0))
        else $error("clear left entries behind");
    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_bus.do_alloc |-> r_used < eff_cap)
        else $error("allocation into full table");

endmodule

FILE: rtl/accumulating_chained_hash_table_top.sv
// Top level of the chained hash table sparse accumulator.
// Depends on acht_pkg, acht_ctrl, acht_dp.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_cmd, i_key, i_value
//  result    out        o_out_valid / i_out_stall o_ok, o_found_value, o_entry_count
//  config    in         i_cfg_wr_en               i_cfg_wr_data (capacity_limit)
//
//  One command at a time. Clear, unknown commands and inserts into a full
//  table go from dispatch straight to the result register; lookup/insert
//  walk the chain, reading and comparing each entry visited in turn through
//  the registered entry memory read port, and an insert adds a write-back.
//  Reset (synchronous, active low) empties every bucket at once via valid
//  bits; capacity returns to 256. A stalled result holds in the output
//  register; the block stays busy until the result can be loaded.

module accumulating_chained_hash_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [8:0]         i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_ok,
    output logic signed [31:0] o_found_value,
    output logic [8:0]         o_entry_count
);

    acht_pkg::t_ctl_cmd ctl_cmd;
    acht_pkg::t_ctl_sts ctl_sts;

    // sequencer: owns the input handshake
    acht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    // storage, arithmetic and the result register
    acht_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_ok          (o_ok),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count),
        .i_cmd_bus     (ctl_cmd),
        .o_sts         (ctl_sts)
    );

endmodule
